// ===== rtl/lrdc_pkg.sv =====
// Shared types, constants and CRC function for the log record deframer.
package lrdc_pkg;

  localparam int unsigned HDR_BYTES = 8 + 1 + 2 + 4;
  localparam int unsigned CRC_BYTES = 4;
  localparam int unsigned SEQ_BYTES = 8;
  localparam int unsigned TYPE_POS  = 8;
  localparam int unsigned KLEN_END  = 11;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam int unsigned OUT_TDATA_W = 200;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_KEY    = 2'd1,
    PH_VALUE  = 2'd2,
    PH_CRC    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_KEY     = 3'd1,
    KIND_VALUE   = 3'd2,
    KIND_CRC     = 3'd3,
    KIND_DISCARD = 3'd4,
    KIND_END     = 3'd5
  } kind_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    kind_t       byte_kind;
    logic        record_done;
    logic        record_ok;
    logic        selected;
    logic [63:0] sequence_res;
    logic [7:0]  entry_type;
    logic [15:0] key_length;
    logic [31:0] value_length;
    logic        halted;
    logic        truncated;
    logic [63:0] highest_sequence;
  } result_t;

  // One byte of reflected CRC-32, bitwise over the eight steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/log_record_deframer_crc_check_unit.sv =====
// Top level of the log record deframer with CRC-32 record check.
//
// Takes a log one byte per item (in_tuser = 1 marks end of log) and returns
// one result item per input item: the byte echoed with its role (header,
// key, value, crc, discarded, end report), the header fields as parsed so
// far, and on the last CRC byte of each record (out_tlast) whether the
// stored big-endian CRC-32 matched and whether it matched with a sequence at or above
// min_sequence. A mismatch halts parsing until end of log; the end-of-log
// item reports truncation and clears all parser state except min_sequence.
// Throughput is one item per clock while out_tready is high; each item passes the
// input register, then the parser's CRC byte update and counters, into the result
// register. The user must write min_sequence through cfg_* only while idle; the block does not enforce this.
module log_record_deframer_crc_check_unit
  import lrdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // config: min_sequence
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [63:0]            cfg_data,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] op
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] out_byte, [8] record_ok,
                                             // [9] selected, [73:10] sequence_res,
                                             // [81:74] entry_type, [97:82] key_length,
                                             // [129:98] value_length, [130] halted,
                                             // [131] truncated, [195:132] highest_sequence,
                                             // [199:196] zero
  output logic [2:0]             out_tuser,  // [2:0] byte_kind
  output logic                   out_tlast   // record_done
);

  logic [63:0] min_seq_r;
  logic        item_vld;
  in_item_t    item;
  logic        take;
  logic        out_free;
  result_t     res;
  result_t     res_r;
  logic        out_vld_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_seq_r <= '0;
    end else if (cfg_valid) begin
      min_seq_r <= cfg_data;
    end
  end

  // result register drains while a new item moves in
  assign out_free = !out_vld_r || out_tready;
  assign take     = item_vld && out_free;

  lrdc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .item_vld  (item_vld),
    .item      (item),
    .take      (take)
  );

  lrdc_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (take),
    .item    (item),
    .min_seq (min_seq_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.byte_kind;
  assign out_tlast  = res_r.record_done;
  assign out_tdata  = {4'd0,
                       res_r.highest_sequence,
                       res_r.truncated,
                       res_r.halted,
                       res_r.value_length,
                       res_r.key_length,
                       res_r.entry_type,
                       res_r.sequence_res,
                       res_r.selected,
                       res_r.record_ok,
                       res_r.out_byte};

endmodule

// ===== rtl/lrdc_in_stage.sv =====
// Input register stage: captures one stream item, releases it when downstream takes it.
module lrdc_in_stage
  import lrdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  output logic       item_vld,
  output in_item_t   item,
  input  logic       take
);

  logic     vld_r;
  in_item_t item_r;

  assign in_tready = !vld_r || take;
  assign item_vld  = vld_r;
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.op        <= in_tuser;
      item_r.data_byte <= in_tdata;
    end
  end

endmodule

// ===== rtl/lrdc_parser.sv =====
// Record parser: header/key/value/CRC phases, CRC update, record report.
module lrdc_parser
  import lrdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  in_item_t    item,
  input  logic [63:0] min_seq,
  output result_t     res
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [63:0] seq_r, seq_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] klen_r, klen_nxt;
  logic [31:0] vlen_r, vlen_nxt;
  logic [31:0] scrc_r, scrc_nxt;
  logic        halt_r, halt_nxt;
  logic [63:0] max_r, max_nxt;

  logic [32:0] cnt_inc;
  logic [31:0] crc_upd;
  logic [31:0] scrc_shift;
  logic        crc_last;
  logic        crc_match;
  logic        is_end;

  assign is_end     = (item.op == OP_END);
  assign cnt_inc    = {1'b0, cnt_r} + 33'd1;
  assign crc_upd    = crc_byte(crc_r, item.data_byte);
  assign scrc_shift = {scrc_r[23:0], item.data_byte};
  assign crc_last   = (cnt_inc >= 33'(CRC_BYTES));
  assign crc_match  = (scrc_shift == (crc_r ^ CRC_ONES));

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    seq_nxt   = seq_r;
    type_nxt  = type_r;
    klen_nxt  = klen_r;
    vlen_nxt  = vlen_r;
    scrc_nxt  = scrc_r;
    halt_nxt  = halt_r;
    max_nxt   = max_r;
    if (is_end) begin
      phase_nxt = PH_HEADER;
      cnt_nxt   = '0;
      crc_nxt   = CRC_ONES;
      seq_nxt   = '0;
      type_nxt  = '0;
      klen_nxt  = '0;
      vlen_nxt  = '0;
      scrc_nxt  = '0;
      halt_nxt  = 1'b0;
      max_nxt   = '0;
    end else if (!halt_r) begin
      unique case (phase_r)
        PH_HEADER: begin
          crc_nxt = crc_upd;
          if (cnt_r < 32'(SEQ_BYTES)) begin
            seq_nxt = {seq_r[55:0], item.data_byte};
          end else if (cnt_r == 32'(TYPE_POS)) begin
            type_nxt = item.data_byte;
          end else if (cnt_r < 32'(KLEN_END)) begin
            klen_nxt = {klen_r[7:0], item.data_byte};
          end else begin
            vlen_nxt = {vlen_r[23:0], item.data_byte};
          end
          cnt_nxt = cnt_inc[31:0];
          if (cnt_inc >= 33'(HDR_BYTES)) begin
            cnt_nxt = '0;
            if (klen_nxt != '0) begin
              phase_nxt = PH_KEY;
            end else if (vlen_nxt != '0) begin
              phase_nxt = PH_VALUE;
            end else begin
              phase_nxt = PH_CRC;
            end
          end
        end
        PH_KEY: begin
          crc_nxt = crc_upd;
          cnt_nxt = cnt_inc[31:0];
          if (cnt_inc >= {17'd0, klen_r}) begin
            cnt_nxt   = '0;
            phase_nxt = (vlen_r != '0) ? PH_VALUE : PH_CRC;
          end
        end
        PH_VALUE: begin
          crc_nxt = crc_upd;
          cnt_nxt = cnt_inc[31:0];
          if (cnt_inc >= {1'b0, vlen_r}) begin
            cnt_nxt   = '0;
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          scrc_nxt = scrc_shift;
          cnt_nxt  = cnt_inc[31:0];
          if (crc_last) begin
            if (crc_match) begin
              if (seq_r > max_r) begin
                max_nxt = seq_r;
              end
            end else begin
              halt_nxt = 1'b1;
            end
            cnt_nxt   = '0;
            crc_nxt   = CRC_ONES;
            phase_nxt = PH_HEADER;
          end
        end
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  // result item
  always_comb begin
    res                  = '0;
    res.out_byte         = is_end ? 8'd0 : item.data_byte;
    res.sequence_res     = is_end ? seq_r : seq_nxt;
    res.entry_type       = is_end ? type_r : type_nxt;
    res.key_length       = is_end ? klen_r : klen_nxt;
    res.value_length     = is_end ? vlen_r : vlen_nxt;
    res.halted           = is_end ? halt_r : halt_nxt;
    res.highest_sequence = is_end ? max_r : max_nxt;
    if (is_end) begin
      res.byte_kind = KIND_END;
      res.truncated = !halt_r && (phase_r != PH_HEADER || cnt_r != '0);
    end else if (halt_r) begin
      res.byte_kind = KIND_DISCARD;
    end else begin
      unique case (phase_r)
        PH_HEADER: res.byte_kind = KIND_HEADER;
        PH_KEY:    res.byte_kind = KIND_KEY;
        PH_VALUE:  res.byte_kind = KIND_VALUE;
        PH_CRC: begin
          res.byte_kind = KIND_CRC;
          if (crc_last) begin
            res.record_done = 1'b1;
            res.record_ok   = crc_match;
            res.selected    = crc_match && (seq_r >= min_seq);
          end
        end
        default: res.byte_kind = KIND_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r   <= '0;
      crc_r   <= CRC_ONES;
      seq_r   <= '0;
      type_r  <= '0;
      klen_r  <= '0;
      vlen_r  <= '0;
      scrc_r  <= '0;
      halt_r  <= 1'b0;
      max_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      seq_r   <= seq_nxt;
      type_r  <= type_nxt;
      klen_r  <= klen_nxt;
      vlen_r  <= vlen_nxt;
      scrc_r  <= scrc_nxt;
      halt_r  <= halt_nxt;
      max_r   <= max_nxt;
    end
  end

endmodule
